// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent check helpers shared by the rtl; empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expression must hold at every clock edge outside reset
`define DIS_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define DIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define DIS_ASSERT(label, clk, rst, expr)
`define DIS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/dis_pkg.sv =====
// ----------------------------------------------------------------------------
// dis_pkg
// shared types and constants of the delimited identifier scanner
// ----------------------------------------------------------------------------
package dis_pkg;

   // character format
   localparam int CHAR_BITS = 16;
   localparam logic [CHAR_BITS-1:0] EOF_CODE = 16'hFFFF;
   localparam logic [CHAR_BITS-1:0] BAR_CODE = 16'h007C;

   // result queue size, room for two results per beat plus slack
   localparam int QUEUE_DEPTH = 4;

   // result kinds
   typedef enum logic [1:0] {
      KIND_DATA     = 2'd0,
      KIND_END      = 2'd1,
      KIND_EOF      = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

   // control broadcast to every cell
   typedef struct packed {
      logic                 load;       // append char to the delimiter
      logic                 clear_win;  // body starts, zero the window
      logic                 shift;      // body char enters the window
      logic [CHAR_BITS-1:0] ch;
   } cell_ctl_type;

   // one result beat
   typedef struct packed {
      kind_type             kind;
      logic [CHAR_BITS-1:0] data_char;
      logic                 last;
   } result_type;

endpackage

// ===== hw/rtl/dis_cell.sv =====
// ----------------------------------------------------------------------------
// dis_cell
// one position of delimiter and tail window, shifting toward cell zero
// ----------------------------------------------------------------------------
module dis_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  dis_pkg::cell_ctl_type          ctl,
   input  logic                           clear_act,    // identifier done, empty delimiter
   input  logic                           prev_active,  // left neighbor in use
   input  logic                           next_active,  // right neighbor in use
   input  logic [dis_pkg::CHAR_BITS-1:0]  next_win,
   input  logic                           next_real,
   output logic                           active,
   output logic [dis_pkg::CHAR_BITS-1:0]  win,
   output logic                           real_char,
   output logic                           eq_next       // next window matches here
);

   logic                          active_ff, active_in;
   logic                          real_ff, real_in;
   logic [dis_pkg::CHAR_BITS-1:0] delim_ff, delim_in;
   logic [dis_pkg::CHAR_BITS-1:0] win_ff, win_in;
   logic                          is_tail;

   // last cell in use takes the new body char
   assign is_tail = active_ff & ~next_active;

   // window and real-char flag
   always_comb begin
      win_in  = win_ff;
      real_in = real_ff;
      if (ctl.clear_win) begin
         win_in  = '0;
         real_in = 1'b0;
      end else if (ctl.shift && active_ff) begin
         if (is_tail) begin
            win_in  = ctl.ch;
            real_in = 1'b1;
         end else begin
            win_in  = next_win;
            real_in = next_real;
         end
      end
   end

   // delimiter slot, written by the first free cell
   always_comb begin
      delim_in  = delim_ff;
      active_in = active_ff;
      if (clear_act) begin
         active_in = 1'b0;
      end else if (ctl.load && prev_active && !active_ff) begin
         active_in = 1'b1;
         delim_in  = ctl.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         real_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         real_ff   <= real_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      delim_ff <= delim_in;
   end

   assign active    = active_ff;
   assign win       = win_ff;
   assign real_char = real_ff;
   assign eq_next   = ~active_ff | (win_in == delim_ff);

endmodule

// ===== hw/rtl/dis_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// dis_rsp_queue
// small result queue taking up to two results per beat, giving one per cycle while the reader is ready
// ----------------------------------------------------------------------------
module dis_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_cnt,
   input  dis_pkg::result_type  push0,
   input  dis_pkg::result_type  push1,
   output logic                 room,      // space for two more results
   output logic                 out_valid,
   input  logic                 out_ready,
   output dis_pkg::result_type  out_res,
   output logic [$clog2(dis_pkg::QUEUE_DEPTH):0] level
);

   localparam int PW = $clog2(dis_pkg::QUEUE_DEPTH);
   localparam int CW = PW + 1;

   dis_pkg::result_type entry_ff [dis_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pop;

   assign pop = out_valid & out_ready;

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff + PW'(push_cnt);
      rd_in  = rd_ff + PW'(pop);
      cnt_in = cnt_ff + CW'(push_cnt) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry writes
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entry_ff[wr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         entry_ff[wr_ff + PW'(1)] <= push1;
      end
   end

   assign out_valid = (cnt_ff != '0);
   assign out_res   = entry_ff[rd_ff];
   assign room      = (cnt_ff <= CW'(dis_pkg::QUEUE_DEPTH - 2));
   assign level     = cnt_ff;

endmodule

// ===== hw/rtl/delimited_identifier_scanner.sv =====
// ----------------------------------------------------------------------------
// delimited_identifier_scanner
// collects a delimiter up to a bar, then streams the body until it matches
// ----------------------------------------------------------------------------
// order: the results of a char are registered in the queue and leave on rsp in order
// throughput: one char per cycle while the queue has room, set by the shift and
//    the combinational compare across the cell row; chars giving two results are
//    held to one result per cycle by the rsp port
// reset: synchronous, clears mode, delimiter length, window flags and queue
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module delimited_identifier_scanner #(
   parameter int MAX_DELIM = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] char_code
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] data_char
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last_of_run
);

   localparam int CB = dis_pkg::CHAR_BITS;
   localparam int QW = $clog2(dis_pkg::QUEUE_DEPTH) + 1;

   logic                 in_body_ff, in_body_in;
   logic                 accept, is_eof, is_bar, full, match;
   logic                 clear_act;
   logic [CB-1:0]        ch;
   dis_pkg::cell_ctl_type ctl;
   logic [MAX_DELIM-1:0] act_w, real_w, eq_w;
   logic [CB-1:0]        win_w [MAX_DELIM];
   logic [1:0]           n_res, push_cnt;
   dis_pkg::result_type  res0, res1, out_res;
   logic                 room;
   logic [QW-1:0]        q_level;

   assign accept = req_tvalid & req_tready;
   assign ch     = req_tdata[CB-1:0];
   assign is_eof = (ch == dis_pkg::EOF_CODE);
   assign is_bar = (ch == dis_pkg::BAR_CODE);
   assign full   = act_w[MAX_DELIM-1];
   assign match  = &eq_w;

   // cell control for this beat
   always_comb begin
      ctl.ch        = ch;
      ctl.load      = accept & ~is_eof & ~in_body_ff & ~is_bar & ~full;
      ctl.clear_win = accept & ~is_eof & ~in_body_ff & is_bar;
      ctl.shift     = accept & ~is_eof & in_body_ff;
   end

   // identifier done, drop the delimiter
   assign clear_act = (ctl.clear_win | ctl.shift) & match;

   // mode register
   always_comb begin
      in_body_in = in_body_ff;
      if (ctl.clear_win && !match) begin
         in_body_in = 1'b1;
      end else if (ctl.shift && match) begin
         in_body_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff <= 1'b0;
      end else begin
         in_body_ff <= in_body_in;
      end
   end

   // cell row
   for (genvar i = 0; i < MAX_DELIM; i++) begin : g_cell
      logic          prev_act, next_act, next_real;
      logic [CB-1:0] next_win;
      if (i == 0) begin : g_first
         assign prev_act = 1'b1;
      end else begin : g_mid
         assign prev_act = act_w[i-1];
      end
      if (i == MAX_DELIM - 1) begin : g_end
         assign next_act  = 1'b0;
         assign next_win  = '0;
         assign next_real = 1'b0;
      end else begin : g_inner
         assign next_act  = act_w[i+1];
         assign next_win  = win_w[i+1];
         assign next_real = real_w[i+1];
      end
      dis_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .clear_act   (clear_act),
         .prev_active (prev_act),
         .next_active (next_act),
         .next_win    (next_win),
         .next_real   (next_real),
         .active      (act_w[i]),
         .win         (win_w[i]),
         .real_char   (real_w[i]),
         .eq_next     (eq_w[i])
      );
   end

   // results of this beat
   always_comb begin
      res0  = '{kind: dis_pkg::KIND_DATA, data_char: '0, last: 1'b0};
      res1  = '{kind: dis_pkg::KIND_END, data_char: '0, last: 1'b1};
      n_res = 2'd0;
      if (is_eof) begin
         res0  = '{kind: dis_pkg::KIND_EOF, data_char: '0, last: 1'b1};
         n_res = 2'd1;
      end else if (!in_body_ff) begin
         if (is_bar) begin
            if (match) begin
               res0  = '{kind: dis_pkg::KIND_END, data_char: '0, last: 1'b1};
               n_res = 2'd1;
            end
         end else if (full) begin
            res0  = '{kind: dis_pkg::KIND_OVERFLOW, data_char: '0, last: 1'b1};
            n_res = 2'd1;
         end
      end else if (real_w[0]) begin
         res0  = '{kind: dis_pkg::KIND_DATA, data_char: win_w[0], last: ~match};
         n_res = match ? 2'd2 : 2'd1;
      end else if (match) begin
         res0  = '{kind: dis_pkg::KIND_END, data_char: '0, last: 1'b1};
         n_res = 2'd1;
      end
   end

   assign push_cnt = accept ? n_res : 2'd0;

   dis_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push0     (res0),
      .push1     (res1),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res),
      .level     (q_level)
   );

   assign req_tready = room;
   assign rsp_tdata  = out_res.data_char;
   assign rsp_tuser  = out_res.kind;
   assign rsp_tlast  = out_res.last;

   // checks
   `DIS_ASSERT(a_body_has_delim, clock, reset, !in_body_ff || act_w[0])
   `DIS_ASSERT(a_delim_contiguous, clock, reset, ((act_w >> 1) & ~act_w) == '0)
   `DIS_ASSERT(a_queue_bound, clock, reset, q_level <= QW'(dis_pkg::QUEUE_DEPTH))
   `DIS_ASSERT_NEXT(a_eof_gives_result, clock, reset, accept && is_eof, rsp_tvalid)

endmodule
